>>> rtl/core/apbc_pkg.sv
// Shared constants, codes and types for the audio playback buffer controller.
package apbc_pkg;

  localparam int unsigned RING_ADDR_BITS = 16;
  localparam int unsigned RING_DEPTH     = 1 << RING_ADDR_BITS;
  localparam int unsigned CNT_W          = RING_ADDR_BITS + 1;
  localparam int unsigned CFG_W          = 17;
  localparam int unsigned CMP_W          = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int unsigned SAMPLE_W       = 16;
  localparam int unsigned FRAME_BITS     = 2 * SAMPLE_W;
  localparam int unsigned FRAME_W        = 30;
  localparam int unsigned MS_W           = 25;
  localparam int unsigned ACTION_W       = 3;
  localparam int unsigned MODE_W         = 2;
  localparam int unsigned CFG_IDX_W      = 1;

  localparam logic [CFG_W-1:0] PREFILL_RESET   = CFG_W'(32768);
  localparam logic [CFG_W-1:0] THRESHOLD_RESET = CFG_W'(57344);

  // 48 frames per ms: drop four bits, then divide by three with a reciprocal
  localparam int unsigned DIV_SHIFT   = 4;
  localparam int unsigned DIV_IN_W    = FRAME_W - DIV_SHIFT;
  localparam int unsigned RECIP_W     = 32;
  localparam int unsigned PROD_W      = DIV_IN_W + RECIP_W;
  localparam int unsigned RECIP_SHIFT = 33;
  localparam logic [RECIP_W-1:0] RECIP_3 = 32'hAAAA_AAAB;

  localparam logic [ACTION_W-1:0] ACT_START = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_POP   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_STOP  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_FAIL  = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_END   = 3'd5;

  localparam logic [MODE_W-1:0] MODE_IDLE    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOADING = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PLAYING = 2'd2;
  localparam logic [MODE_W-1:0] MODE_ERROR   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_PREFILL   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_EXEC    = 5'b00010,
    S_MUL_POS = 5'b00100,
    S_MUL_DUR = 5'b01000,
    S_DONE    = 5'b10000
  } ctl_state_e;

  typedef struct packed {
    logic latch;
    logic exec;
    logic mul_pos;
    logic mul_dur;
  } dp_cmd_t;

endpackage

>>> rtl/core/apbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module apbc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/core/apbc_ctrl.sv
// Sequencer that steps each item through execute, two divide steps and the result cycle.
module apbc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  output logic             out_valid_o,
  output apbc_pkg::dp_cmd_t cmd_o
);

  apbc_pkg::ctl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      apbc_pkg::S_IDLE: begin
        if (start_i) begin
          state_d = apbc_pkg::S_EXEC;
        end
      end
      apbc_pkg::S_EXEC:    state_d = apbc_pkg::S_MUL_POS;
      apbc_pkg::S_MUL_POS: state_d = apbc_pkg::S_MUL_DUR;
      apbc_pkg::S_MUL_DUR: state_d = apbc_pkg::S_DONE;
      apbc_pkg::S_DONE:    state_d = apbc_pkg::S_IDLE;
      default:             state_d = apbc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= apbc_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o        = (state_q != apbc_pkg::S_IDLE);
  assign out_valid_o   = (state_q == apbc_pkg::S_DONE);
  assign cmd_o.latch   = (state_q == apbc_pkg::S_IDLE) && start_i;
  assign cmd_o.exec    = (state_q == apbc_pkg::S_EXEC);
  assign cmd_o.mul_pos = (state_q == apbc_pkg::S_MUL_POS);
  assign cmd_o.mul_dur = (state_q == apbc_pkg::S_MUL_DUR);

endmodule

>>> rtl/core/apbc_dp.sv
// Datapath: ring counters, player mode, frame counts, ring memory and ms divider.
module apbc_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  apbc_pkg::dp_cmd_t                   cmd_i,
  input  logic [apbc_pkg::ACTION_W-1:0]       action_i,
  input  logic signed [apbc_pkg::SAMPLE_W-1:0] in_left_i,
  input  logic signed [apbc_pkg::SAMPLE_W-1:0] in_right_i,
  input  logic [apbc_pkg::FRAME_W-1:0]        stream_frames_i,
  input  logic                                cfg_we_i,
  input  logic [apbc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [apbc_pkg::CFG_W-1:0]          cfg_wdata_i,
  output logic signed [apbc_pkg::SAMPLE_W-1:0] out_left_o,
  output logic signed [apbc_pkg::SAMPLE_W-1:0] out_right_o,
  output logic                                from_buffer_o,
  output logic [apbc_pkg::MODE_W-1:0]         mode_o,
  output logic                                refill_request_o,
  output logic                                accepted_o,
  output logic [apbc_pkg::MS_W-1:0]           position_ms_o,
  output logic [apbc_pkg::MS_W-1:0]           duration_ms_o
);

  localparam int unsigned AW = apbc_pkg::RING_ADDR_BITS;
  localparam int unsigned CW = apbc_pkg::CNT_W;
  localparam int unsigned SW = apbc_pkg::SAMPLE_W;
  localparam int unsigned FW = apbc_pkg::FRAME_W;

  // latched item
  logic [apbc_pkg::ACTION_W-1:0] action_q;
  logic [SW-1:0]                 left_q, right_q;
  logic [FW-1:0]                 sframes_q;

  // control state
  logic [apbc_pkg::CFG_W-1:0]  prefill_q, threshold_q;
  logic [CW-1:0]               wc_q, wc_d, rc_q, rc_d;
  logic [apbc_pkg::MODE_W-1:0] mode_q, mode_d;
  logic                        done_q, done_d;
  logic [FW-1:0]               loaded_q, loaded_d, total_q, total_d, played_q, played_d;

  // result registers
  logic [SW-1:0]             oleft_q, oleft_d, oright_q, oright_d;
  logic                      from_q, from_d, acc_q, acc_d, refill_q, refill_d;
  logic [apbc_pkg::MS_W-1:0] pos_q, dur_q;

  logic [CW-1:0]                     fill, fill_inc, fill_dec, fill_d;
  logic [FW-1:0]                     loaded_inc;
  logic                              active, ram_we;
  logic [apbc_pkg::FRAME_BITS-1:0]   ram_rdata;
  logic [apbc_pkg::DIV_IN_W-1:0]     mul_a;
  logic [apbc_pkg::PROD_W-1:0]       prod;
  logic [apbc_pkg::MS_W-1:0]         quot;

  apbc_ram #(
    .WIDTH(apbc_pkg::FRAME_BITS),
    .DEPTH(apbc_pkg::RING_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wc_q[AW-1:0]),
    .wdata_i({right_q, left_q}),
    .raddr_i(rc_q[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  assign fill       = wc_q - rc_q;
  assign fill_inc   = fill + 1'b1;
  assign fill_dec   = (fill != '0) ? fill - 1'b1 : fill;
  assign loaded_inc = loaded_q + 1'b1;
  assign active     = (mode_q == apbc_pkg::MODE_LOADING) || (mode_q == apbc_pkg::MODE_PLAYING);

  always_comb begin
    wc_d     = wc_q;
    rc_d     = rc_q;
    mode_d   = mode_q;
    done_d   = done_q;
    loaded_d = loaded_q;
    total_d  = total_q;
    played_d = played_q;
    oleft_d  = '0;
    oright_d = '0;
    from_d   = 1'b0;
    acc_d    = 1'b0;
    ram_we   = 1'b0;
    unique case (action_q)
      apbc_pkg::ACT_START: begin
        if (mode_q == apbc_pkg::MODE_IDLE) begin
          total_d  = sframes_q;
          loaded_d = '0;
          played_d = '0;
          wc_d     = '0;
          rc_d     = '0;
          done_d   = (sframes_q == '0);
          mode_d   = (done_d || (prefill_q == '0)) ? apbc_pkg::MODE_PLAYING
                                                   : apbc_pkg::MODE_LOADING;
          acc_d    = 1'b1;
        end
      end
      apbc_pkg::ACT_PUSH: begin
        if (active && !done_q && !fill[AW]) begin
          ram_we   = cmd_i.exec;
          wc_d     = wc_q + 1'b1;
          loaded_d = loaded_inc;
          done_d   = (loaded_inc >= total_q);
          if ((mode_q == apbc_pkg::MODE_LOADING) &&
              (done_d || (apbc_pkg::CMP_W'(fill_inc) >= apbc_pkg::CMP_W'(prefill_q)))) begin
            mode_d = apbc_pkg::MODE_PLAYING;
          end
          acc_d    = 1'b1;
        end
      end
      apbc_pkg::ACT_POP: begin
        if (mode_q == apbc_pkg::MODE_PLAYING) begin
          if (fill != '0) begin
            oleft_d  = ram_rdata[SW-1:0];
            oright_d = ram_rdata[2*SW-1:SW];
            from_d   = 1'b1;
            rc_d     = rc_q + 1'b1;
            played_d = played_q + 1'b1;
          end
          if (done_q && (fill_dec == '0)) begin
            mode_d = apbc_pkg::MODE_IDLE;
          end
          acc_d = 1'b1;
        end
      end
      apbc_pkg::ACT_STOP: begin
        if (mode_q != apbc_pkg::MODE_IDLE) begin
          rc_d   = wc_q;
          done_d = 1'b1;
          mode_d = apbc_pkg::MODE_IDLE;
          acc_d  = 1'b1;
        end
      end
      apbc_pkg::ACT_FAIL: begin
        if (active) begin
          mode_d = apbc_pkg::MODE_ERROR;
          done_d = 1'b1;
          acc_d  = 1'b1;
        end
      end
      apbc_pkg::ACT_END: begin
        if (active && !done_q) begin
          done_d = 1'b1;
          if (mode_q == apbc_pkg::MODE_LOADING) begin
            mode_d = apbc_pkg::MODE_PLAYING;
          end
          acc_d = 1'b1;
        end
      end
      default: begin
        acc_d = 1'b0;
      end
    endcase
  end

  assign fill_d   = wc_d - rc_d;
  assign refill_d = !done_d &&
                    (apbc_pkg::CMP_W'(fill_d) <= apbc_pkg::CMP_W'(threshold_q));

  // frames / 48 = (frames >> 4) / 3, one shared multiplier
  assign mul_a = cmd_i.mul_pos ? played_q[FW-1:apbc_pkg::DIV_SHIFT]
                               : total_q[FW-1:apbc_pkg::DIV_SHIFT];
  assign prod  = apbc_pkg::PROD_W'(mul_a) * apbc_pkg::PROD_W'(apbc_pkg::RECIP_3);
  assign quot  = prod[apbc_pkg::RECIP_SHIFT +: apbc_pkg::MS_W];

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      action_q  <= action_i;
      left_q    <= in_left_i;
      right_q   <= in_right_i;
      sframes_q <= stream_frames_i;
    end
    if (cmd_i.exec) begin
      oleft_q  <= oleft_d;
      oright_q <= oright_d;
      from_q   <= from_d;
      acc_q    <= acc_d;
      refill_q <= refill_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefill_q   <= apbc_pkg::PREFILL_RESET;
      threshold_q <= apbc_pkg::THRESHOLD_RESET;
      wc_q        <= '0;
      rc_q        <= '0;
      mode_q      <= apbc_pkg::MODE_IDLE;
      done_q      <= 1'b1;
      loaded_q    <= '0;
      total_q     <= '0;
      played_q    <= '0;
      pos_q       <= '0;
      dur_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          apbc_pkg::REG_PREFILL:   prefill_q   <= cfg_wdata_i;
          apbc_pkg::REG_THRESHOLD: threshold_q <= cfg_wdata_i;
          default:                 prefill_q   <= prefill_q;
        endcase
      end
      if (cmd_i.exec) begin
        wc_q     <= wc_d;
        rc_q     <= rc_d;
        mode_q   <= mode_d;
        done_q   <= done_d;
        loaded_q <= loaded_d;
        total_q  <= total_d;
        played_q <= played_d;
      end
      if (cmd_i.mul_pos) begin
        pos_q <= quot;
      end
      if (cmd_i.mul_dur) begin
        dur_q <= quot;
      end
    end
  end

  assign out_left_o       = oleft_q;
  assign out_right_o      = oright_q;
  assign from_buffer_o    = from_q;
  assign mode_o           = mode_q;
  assign refill_request_o = refill_q;
  assign accepted_o       = acc_q;
  assign position_ms_o    = pos_q;
  assign duration_ms_o    = dur_q;

endmodule

>>> rtl/core/audio_playback_buffer_controller_top.sv
// Top level of the audio playback buffer controller.
//
// Usage: drive action_i, the sample ports and stream_frames_i with start_i high while
// busy_o is low; the item is taken at that clock edge. Each item gives exactly one
// result: out_valid_o is high for one cycle, in the done state after the execute,
// position and duration states, with out_left_o, out_right_o, from_buffer_o, mode_o,
// refill_request_o, accepted_o, position_ms_o and duration_ms_o valid in that cycle.
// The receiver cannot stall; results must be taken when out_valid_o is high.
// busy_o stays high until the result is out, so items never overlap. The execute
// state applies the item to the ring counters and mode, using ring data that the
// registered RAM read port has already fetched at the read pointer; the position
// and duration states share one reciprocal multiplier for the values in ms.
// Configuration: cfg_we_i, cfg_index_i (0 prefill level, 1 refill threshold) and
// cfg_wdata_i write a register at the clock edge; write only while busy_o is low.
// Reset (rst_ni low, asynchronous): mode idle, stream ended, counters zero, prefill
// 32768 and threshold 57344. The ring memory is not cleared; only frames written
// since the last start are ever read back.
module audio_playback_buffer_controller_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic [apbc_pkg::ACTION_W-1:0]        action_i,
  input  logic signed [apbc_pkg::SAMPLE_W-1:0] in_left_i,
  input  logic signed [apbc_pkg::SAMPLE_W-1:0] in_right_i,
  input  logic [apbc_pkg::FRAME_W-1:0]         stream_frames_i,
  input  logic                                 cfg_we_i,
  input  logic [apbc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [apbc_pkg::CFG_W-1:0]           cfg_wdata_i,
  output logic                                 out_valid_o,
  output logic signed [apbc_pkg::SAMPLE_W-1:0] out_left_o,
  output logic signed [apbc_pkg::SAMPLE_W-1:0] out_right_o,
  output logic                                 from_buffer_o,
  output logic [apbc_pkg::MODE_W-1:0]          mode_o,
  output logic                                 refill_request_o,
  output logic                                 accepted_o,
  output logic [apbc_pkg::MS_W-1:0]            position_ms_o,
  output logic [apbc_pkg::MS_W-1:0]            duration_ms_o
);

  apbc_pkg::dp_cmd_t cmd;

  apbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .out_valid_o(out_valid_o),
    .cmd_o      (cmd)
  );

  apbc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .action_i        (action_i),
    .in_left_i       (in_left_i),
    .in_right_i      (in_right_i),
    .stream_frames_i (stream_frames_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .out_left_o      (out_left_o),
    .out_right_o     (out_right_o),
    .from_buffer_o   (from_buffer_o),
    .mode_o          (mode_o),
    .refill_request_o(refill_request_o),
    .accepted_o      (accepted_o),
    .position_ms_o   (position_ms_o),
    .duration_ms_o   (duration_ms_o)
  );

endmodule

>>> rtl/core/apbc_checker.sv
// Port-level checker for the audio playback buffer controller, bound to the top level.
module apbc_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 start_i,
  input logic                                 busy_o,
  input logic                                 out_valid_o,
  input logic                                 from_buffer_o,
  input logic                                 accepted_o,
  input logic signed [apbc_pkg::SAMPLE_W-1:0] out_left_o,
  input logic [apbc_pkg::MODE_W-1:0]          mode_o
);

  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##4 out_valid_o)
    else $error("result not delivered four cycles after item");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |=> !out_valid_o)
    else $error("result strobe longer than one cycle");

  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> busy_o)
    else $error("result strobe while not busy");

  a_buffer_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && from_buffer_o |-> accepted_o &&
      (mode_o == apbc_pkg::MODE_PLAYING || mode_o == apbc_pkg::MODE_IDLE))
    else $error("frame from ring without accepted pop");

  a_silence_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !from_buffer_o |-> out_left_o == '0)
    else $error("silence with nonzero sample");

endmodule

bind audio_playback_buffer_controller_top apbc_checker u_apbc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .out_valid_o  (out_valid_o),
  .from_buffer_o(from_buffer_o),
  .accepted_o   (accepted_o),
  .out_left_o   (out_left_o),
  .mode_o       (mode_o)
);

>>> verif/apbc_player_checker.sv
`timescale 1ns / 1ps
// Checker that tracks the playback player and compares every report of the controller.
module apbc_player_checker
  import apbc_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  logic [ACTION_W-1:0]        action_i,
  input  logic signed [SAMPLE_W-1:0] in_left_i,
  input  logic signed [SAMPLE_W-1:0] in_right_i,
  input  logic [FRAME_W-1:0]         stream_frames_i,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_W-1:0]           cfg_wdata_i,
  input  logic                       out_valid_i,
  input  logic signed [SAMPLE_W-1:0] out_left_i,
  input  logic signed [SAMPLE_W-1:0] out_right_i,
  input  logic                       from_buffer_i,
  input  logic [MODE_W-1:0]          mode_i,
  input  logic                       refill_request_i,
  input  logic                       accepted_i,
  input  logic [MS_W-1:0]            position_ms_i,
  input  logic [MS_W-1:0]            duration_ms_i,
  output int                         err_count_o,
  output int                         pending_o
);

  localparam int unsigned FRAMES_PER_MS = 48;
  localparam int unsigned MAX_REPORTS   = 10;

  typedef struct {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic                       from_buf;
    logic [MODE_W-1:0]          mode;
    logic                       refill;
    logic                       acc;
    logic [MS_W-1:0]            pos_ms;
    logic [MS_W-1:0]            dur_ms;
  } player_report_t;

  logic [FRAME_BITS-1:0] ring_mem [RING_DEPTH];
  logic [CNT_W-1:0]      wr_ptr;
  logic [CNT_W-1:0]      rd_ptr;
  logic [MODE_W-1:0]     play_mode;
  logic                  ended;
  logic [FRAME_W-1:0]    n_loaded;
  logic [FRAME_W-1:0]    n_total;
  logic [FRAME_W-1:0]    n_played;
  logic [CFG_W-1:0]      prefill_lvl;
  logic [CFG_W-1:0]      refill_thr;

  player_report_t due_reports [$];
  player_report_t want;
  logic           bad;
  int             mismatches = 0;

  function automatic logic [CNT_W-1:0] fill_level();
    return wr_ptr - rd_ptr;
  endfunction

  function automatic void settle_loading();
    if (play_mode == MODE_LOADING && (ended || fill_level() >= prefill_lvl)) begin
      play_mode = MODE_PLAYING;
    end
  endfunction

  function automatic player_report_t play_item(input logic [ACTION_W-1:0] act,
                                               input logic [SAMPLE_W-1:0] left,
                                               input logic [SAMPLE_W-1:0] right,
                                               input logic [FRAME_W-1:0]  len);
    player_report_t rep;
    logic           active;
    rep.left     = '0;
    rep.right    = '0;
    rep.from_buf = 1'b0;
    rep.acc      = 1'b0;
    active = (play_mode == MODE_LOADING) || (play_mode == MODE_PLAYING);
    case (act)
      ACT_START: begin
        if (play_mode == MODE_IDLE) begin
          n_total   = len;
          n_loaded  = '0;
          n_played  = '0;
          wr_ptr    = '0;
          rd_ptr    = '0;
          ended     = (len == '0);
          play_mode = MODE_LOADING;
          settle_loading();
          rep.acc = 1'b1;
        end
      end
      ACT_PUSH: begin
        if (active && !ended && fill_level() < RING_DEPTH) begin
          ring_mem[wr_ptr[RING_ADDR_BITS-1:0]] = {right, left};
          wr_ptr   = wr_ptr + 1'b1;
          n_loaded = n_loaded + 1'b1;
          if (n_loaded >= n_total) begin
            ended = 1'b1;
          end
          settle_loading();
          rep.acc = 1'b1;
        end
      end
      ACT_POP: begin
        if (play_mode == MODE_PLAYING) begin
          if (fill_level() != '0) begin
            {rep.right, rep.left} = ring_mem[rd_ptr[RING_ADDR_BITS-1:0]];
            rep.from_buf = 1'b1;
            rd_ptr   = rd_ptr + 1'b1;
            n_played = n_played + 1'b1;
          end
          if (ended && fill_level() == '0) begin
            play_mode = MODE_IDLE;
          end
          rep.acc = 1'b1;
        end
      end
      ACT_STOP: begin
        if (play_mode != MODE_IDLE) begin
          rd_ptr    = wr_ptr;
          ended     = 1'b1;
          play_mode = MODE_IDLE;
          rep.acc   = 1'b1;
        end
      end
      ACT_FAIL: begin
        if (active) begin
          play_mode = MODE_ERROR;
          ended     = 1'b1;
          rep.acc   = 1'b1;
        end
      end
      ACT_END: begin
        if (active && !ended) begin
          ended = 1'b1;
          settle_loading();
          rep.acc = 1'b1;
        end
      end
      default: begin
      end
    endcase
    rep.mode   = play_mode;
    rep.refill = !ended && (fill_level() <= refill_thr);
    rep.pos_ms = MS_W'(n_played / FRAMES_PER_MS);
    rep.dur_ms = MS_W'(n_total / FRAMES_PER_MS);
    return rep;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr      = '0;
      rd_ptr      = '0;
      play_mode   = MODE_IDLE;
      ended       = 1'b1;
      n_loaded    = '0;
      n_total     = '0;
      n_played    = '0;
      prefill_lvl = PREFILL_RESET;
      refill_thr  = THRESHOLD_RESET;
      due_reports.delete();
      pending_o   <= 0;
      err_count_o <= mismatches;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_PREFILL) begin
          prefill_lvl = cfg_wdata_i;
        end else if (cfg_index_i == REG_THRESHOLD) begin
          refill_thr = cfg_wdata_i;
        end
      end
      if (out_valid_i) begin
        if (due_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: report with no item outstanding", $time);
          end
        end else begin
          want = due_reports.pop_front();
          bad = (out_left_i !== want.left) || (out_right_i !== want.right) ||
                (from_buffer_i !== want.from_buf) || (mode_i !== want.mode) ||
                (refill_request_i !== want.refill) || (accepted_i !== want.acc) ||
                (position_ms_i !== want.pos_ms) || (duration_ms_i !== want.dur_ms);
          if (bad) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("%0t: exp L=%0d R=%0d fb=%0b mode=%0d rr=%0b acc=%0b pos=%0d dur=%0d",
                       $time, want.left, want.right, want.from_buf, want.mode,
                       want.refill, want.acc, want.pos_ms, want.dur_ms);
              $display("%0t: got L=%0d R=%0d fb=%0b mode=%0d rr=%0b acc=%0b pos=%0d dur=%0d",
                       $time, out_left_i, out_right_i, from_buffer_i, mode_i,
                       refill_request_i, accepted_i, position_ms_i, duration_ms_i);
            end
          end
        end
      end
      if (start_i && !busy_i) begin
        due_reports.push_back(play_item(action_i, in_left_i, in_right_i, stream_frames_i));
      end
      pending_o   <= due_reports.size();
      err_count_o <= mismatches;
    end
  end

endmodule

>>> verif/audio_playback_buffer_controller_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the playback buffer controller: item stimulus, register setup and verdict.
module audio_playback_buffer_controller_top_tb;
  import apbc_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_7 = 3'd7;
  localparam int unsigned         RAND_ITEMS  = 1300;
  localparam int unsigned         N_PHASES    = 6;

  logic                       clk_i           = 1'b0;
  logic                       rst_ni          = 1'b0;
  logic                       start_i         = 1'b0;
  logic [ACTION_W-1:0]        action_i        = ACT_POP;
  logic signed [SAMPLE_W-1:0] in_left_i       = '0;
  logic signed [SAMPLE_W-1:0] in_right_i      = '0;
  logic [FRAME_W-1:0]         stream_frames_i = '0;
  logic                       cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index_i     = REG_PREFILL;
  logic [CFG_W-1:0]           cfg_wdata_i     = '0;
  logic                       busy_o;
  logic                       out_valid_o;
  logic signed [SAMPLE_W-1:0] out_left_o;
  logic signed [SAMPLE_W-1:0] out_right_o;
  logic                       from_buffer_o;
  logic [MODE_W-1:0]          mode_o;
  logic                       refill_request_o;
  logic                       accepted_o;
  logic [MS_W-1:0]            position_ms_o;
  logic [MS_W-1:0]            duration_ms_o;

  int err_count;
  int pending;
  int idle_pct = 0;
  int sent     = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  audio_playback_buffer_controller_top dut (.*);

  apbc_player_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_i           (busy_o),
    .action_i         (action_i),
    .in_left_i        (in_left_i),
    .in_right_i       (in_right_i),
    .stream_frames_i  (stream_frames_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .out_valid_i      (out_valid_o),
    .out_left_i       (out_left_o),
    .out_right_i      (out_right_o),
    .from_buffer_i    (from_buffer_o),
    .mode_i           (mode_o),
    .refill_request_i (refill_request_o),
    .accepted_i       (accepted_o),
    .position_ms_i    (position_ms_o),
    .duration_ms_i    (duration_ms_o),
    .err_count_o      (err_count),
    .pending_o        (pending)
  );

  task automatic send_item(input logic [ACTION_W-1:0] act, input logic [SAMPLE_W-1:0] left,
                           input logic [SAMPLE_W-1:0] right, input logic [FRAME_W-1:0] len);
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i         <= 1'b1;
    action_i        <= act;
    in_left_i       <= left;
    in_right_i      <= right;
    stream_frames_i <= len;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (act != ACT_SPARE_6 && act != ACT_SPARE_7) begin
      sent++;
    end
  endtask

  task automatic issue(input logic [ACTION_W-1:0] act);
    send_item(act, SAMPLE_W'($urandom()), SAMPLE_W'($urandom()), FRAME_W'($urandom()));
  endtask

  task automatic quiesce();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy_o) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    quiesce();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [FRAME_W-1:0] pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 70) return FRAME_W'($urandom_range(1, 100));
    if (r < 90) return FRAME_W'($urandom_range(101, 4000));
    return FRAME_W'($urandom());
  endfunction

  task automatic run_session();
    int unsigned r;
    int unsigned ops;
    send_item(ACT_START, SAMPLE_W'($urandom()), SAMPLE_W'($urandom()), pick_length());
    ops = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 400) : $urandom_range(4, 90);
    repeat (ops) begin
      r = $urandom_range(0, 999);
      if (r < 460) issue(ACT_PUSH);
      else if (r < 830) issue(ACT_POP);
      else if (r < 870) issue(ACT_END);
      else if (r < 880) issue(ACT_STOP);
      else if (r < 886) issue(ACT_FAIL);
      else if (r < 900) send_item(ACT_START, SAMPLE_W'($urandom()), SAMPLE_W'($urandom()),
                                  pick_length());
      else if (r < 930) issue(ACTION_W'($urandom_range(0, 7)));
      else issue(ACT_POP);
    end
    if ($urandom_range(0, 3) != 0) issue(ACT_END);
    repeat ($urandom_range(0, 20)) issue(ACT_POP);
    if ($urandom_range(0, 2) != 0) issue(ACT_STOP);
    if ($urandom_range(0, 19) == 0) quiesce();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue(ACT_POP);
    issue(ACT_STOP);
    issue(ACT_FAIL);
    issue(ACT_END);
    issue(ACT_PUSH);
    issue(ACT_SPARE_6);
    issue(ACT_SPARE_7);
    send_item(ACT_START, '0, '0, '0);
    issue(ACT_START);
    issue(ACT_POP);

    write_reg(REG_PREFILL, CFG_W'(2));
    write_reg(REG_THRESHOLD, CFG_W'(1));
    send_item(ACT_START, '0, '0, FRAME_W'(3));
    send_item(ACT_PUSH, 16'h7FFF, 16'h8000, '0);
    send_item(ACT_PUSH, 16'h8000, 16'h7FFF, '1);
    send_item(ACT_PUSH, 16'hFFFF, 16'h0000, '0);
    issue(ACT_PUSH);
    repeat (4) issue(ACT_POP);
    send_item(ACT_START, '0, '0, '1);
    issue(ACT_PUSH);
    issue(ACT_FAIL);
    issue(ACT_PUSH);
    issue(ACT_FAIL);
    issue(ACT_STOP);
    send_item(ACT_START, '0, '0, FRAME_W'(10));
    issue(ACT_PUSH);
    issue(ACT_END);
    issue(ACT_END);
    issue(ACT_POP);

    sent = 0;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_PREFILL, '0);
          write_reg(REG_THRESHOLD, CFG_W'(RING_DEPTH));
        end
        1: begin
          write_reg(REG_PREFILL, CFG_W'(8));
          write_reg(REG_THRESHOLD, CFG_W'(16));
        end
        2: begin
          write_reg(REG_PREFILL, CFG_W'($urandom_range(0, 64)));
          write_reg(REG_THRESHOLD, CFG_W'($urandom_range(0, 64)));
        end
        3: begin
          write_reg(REG_PREFILL, CFG_W'(RING_DEPTH));
          write_reg(REG_THRESHOLD, '0);
        end
        4: begin
          write_reg(REG_PREFILL, CFG_W'($urandom_range(0, 200)));
          write_reg(REG_THRESHOLD, CFG_W'($urandom_range(0, 4000)));
        end
        default: begin
          write_reg(REG_PREFILL, CFG_W'(1));
          write_reg(REG_THRESHOLD, CFG_W'(3));
        end
      endcase
      case (ph % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 79;
        default: idle_pct = 7;
      endcase
      while (sent < (ph + 1) * RAND_ITEMS / N_PHASES) run_session();
    end

    quiesce();
    repeat (20) @(posedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #24_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
